/* sv/sha1_pkg.sv */
// ----------------------------------------------------------------------------
// sha1_pkg: shared types, constants and round functions for the SHA-1 core
// Transaction payloads, controller/datapath command and status, round logic.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } result_t;

    typedef logic [4:0][31:0] chain_t;

    localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] LEN_LAST   = 3'd7;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    // source of the byte shifted into the block register
    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        byte_sel_t  sel;
        logic       push;      // shift one byte into the block
        logic       count;     // bump message length
        logic       load;      // working vars <= chain
        logic       round;     // run one compression round
        logic       fold;      // chain += working vars
        logic       out_load;  // capture one digest word
        logic       reinit;    // back to initial chain, zero length
        logic [6:0] rnd;
        logic [2:0] len_idx;
        logic [2:0] word_idx;
    } cmd_t;

    typedef struct packed {
        logic [5:0] fill_count;
    } status_t;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20)
            k = K_0;
        else if (rnd < 7'd40)
            k = K_1;
        else if (rnd < 7'd60)
            k = K_2;
        else
            k = K_3;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20)
            f = (b & c) | (~b & d);
        else if (rnd < 7'd40)
            f = b ^ c ^ d;
        else if (rnd < 7'd60)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

/* sv/sha1_ctrl.sv */
// ----------------------------------------------------------------------------
// sha1_ctrl: SHA-1 sequencer
// Intake, padding, compression rounds and digest readout control.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                has_byte,
    input  logic                last_byte,
    output logic                result_valid,
    input  logic                result_ready,
    input  sha1_pkg::status_t   sts,
    output sha1_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZFILL,
        ST_LEN,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    state_t     resume_reg, resume_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] len_idx_reg, len_idx_next;
    logic [2:0] word_idx_reg, word_idx_next;
    logic       out_valid_reg, out_valid_next;
    logic       full;

    assign full = (sts.fill_count == sha1_pkg::FILL_LAST);

    always_comb
    begin
        state_next    = state_reg;
        resume_next   = resume_reg;
        round_next    = round_reg;
        len_idx_next  = len_idx_reg;
        word_idx_next = word_idx_reg;
        item_ready    = 1'b0;
        cmd           = '0;
        cmd.sel       = sha1_pkg::SEL_DATA;
        cmd.rnd       = round_reg;
        cmd.len_idx   = len_idx_reg;
        cmd.word_idx  = word_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (has_byte)
                    begin
                        cmd.push  = 1'b1;
                        cmd.count = 1'b1;
                    end
                    if (has_byte && full)
                    begin
                        cmd.load    = 1'b1;
                        round_next  = '0;
                        state_next  = ST_COMP;
                        resume_next = last_byte ? ST_PAD : ST_IDLE;
                    end
                    else if (last_byte)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                cmd.sel  = sha1_pkg::SEL_PAD;
                cmd.push = 1'b1;
                if (full)
                begin
                    cmd.load    = 1'b1;
                    round_next  = '0;
                    state_next  = ST_COMP;
                    resume_next = ST_ZFILL;
                end
                else
                    state_next = ST_ZFILL;
            end
            ST_ZFILL:
            begin
                if (sts.fill_count == sha1_pkg::LEN_OFFSET)
                begin
                    len_idx_next = '0;
                    state_next   = ST_LEN;
                end
                else
                begin
                    cmd.sel  = sha1_pkg::SEL_ZERO;
                    cmd.push = 1'b1;
                    if (full)
                    begin
                        cmd.load    = 1'b1;
                        round_next  = '0;
                        state_next  = ST_COMP;
                        resume_next = ST_ZFILL;
                    end
                end
            end
            ST_LEN:
            begin
                cmd.sel      = sha1_pkg::SEL_LEN;
                cmd.push     = 1'b1;
                len_idx_next = len_idx_reg + 3'd1;
                if (len_idx_reg == sha1_pkg::LEN_LAST)
                begin
                    cmd.load      = 1'b1;
                    round_next    = '0;
                    word_idx_next = '0;
                    state_next    = ST_COMP;
                    resume_next   = ST_OUT;
                end
            end
            ST_COMP:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == sha1_pkg::ROUND_LAST)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = resume_reg;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load  = 1'b1;
                    word_idx_next = word_idx_reg + 3'd1;
                    if (word_idx_reg == sha1_pkg::WORD_LAST)
                    begin
                        cmd.reinit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            resume_reg    <= ST_IDLE;
            round_reg     <= '0;
            len_idx_reg   <= '0;
            word_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            resume_reg    <= resume_next;
            round_reg     <= round_next;
            len_idx_reg   <= len_idx_next;
            word_idx_reg  <= word_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/sha1_datapath.sv */
// ----------------------------------------------------------------------------
// sha1_datapath: SHA-1 block register, round unit and chaining words
// 512-bit block doubles as the 16-word message schedule window.
// ----------------------------------------------------------------------------
module sha1_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::cmd_t      cmd,
    input  logic [7:0]          data_byte,
    output sha1_pkg::status_t   sts,
    output sha1_pkg::result_t   result
);

    logic [511:0]      blk_reg, blk_next;
    logic [5:0]        fill_reg, fill_next;
    logic [60:0]       msg_reg, msg_next;
    sha1_pkg::chain_t  h_reg, h_next;
    sha1_pkg::chain_t  wv_reg, wv_next;   // [0]=a .. [4]=e
    sha1_pkg::result_t out_reg, out_next;

    logic [7:0]  in_byte;
    logic [63:0] len_bits;
    logic [31:0] w0, w_new, t_sum;

    assign len_bits = {msg_reg, 3'b000};
    assign w0       = blk_reg[511:480];
    // w[t+16] = rol1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t])
    assign w_new    = sha1_pkg::rol32(blk_reg[95:64] ^ blk_reg[255:224]
                                      ^ blk_reg[447:416] ^ w0, 1);
    assign t_sum    = sha1_pkg::rol32(wv_reg[0], 5)
                    + sha1_pkg::round_f(cmd.rnd, wv_reg[1], wv_reg[2], wv_reg[3])
                    + wv_reg[4] + sha1_pkg::round_k(cmd.rnd) + w0;

    always_comb
    begin
        case (cmd.sel)
            sha1_pkg::SEL_DATA: in_byte = data_byte;
            sha1_pkg::SEL_PAD:  in_byte = sha1_pkg::PAD_BYTE;
            sha1_pkg::SEL_ZERO: in_byte = 8'h00;
            sha1_pkg::SEL_LEN:  in_byte = len_bits[8 * (7 - cmd.len_idx) +: 8];
            default:            in_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        blk_next = blk_reg;
        fill_next = fill_reg;
        msg_next = msg_reg;
        h_next   = h_reg;
        wv_next  = wv_reg;
        out_next = out_reg;

        if (cmd.push)
        begin
            blk_next  = {blk_reg[503:0], in_byte};
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.count)
            msg_next = msg_reg + 61'd1;
        if (cmd.load)
            wv_next = h_reg;
        if (cmd.round)
        begin
            blk_next  = {blk_reg[479:0], w_new};
            wv_next[0] = t_sum;
            wv_next[1] = wv_reg[0];
            wv_next[2] = sha1_pkg::rol32(wv_reg[1], 30);
            wv_next[3] = wv_reg[2];
            wv_next[4] = wv_reg[3];
        end
        if (cmd.fold)
        begin
            for (int i = 0; i < 5; i++)
                h_next[i] = h_reg[i] + wv_reg[i];
        end
        if (cmd.out_load)
        begin
            out_next.digest_word = h_reg[cmd.word_idx];
            out_next.word_index  = cmd.word_idx;
            out_next.last_word   = (cmd.word_idx == sha1_pkg::WORD_LAST);
        end
        if (cmd.reinit)
        begin
            h_next    = sha1_pkg::H_INIT;
            msg_next  = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            msg_reg  <= '0;
            h_reg    <= sha1_pkg::H_INIT;
        end
        else
        begin
            fill_reg <= fill_next;
            msg_reg  <= msg_next;
            h_reg    <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        wv_reg  <= wv_next;
        out_reg <= out_next;
    end

    assign sts.fill_count = fill_reg;
    assign result         = out_reg;

endmodule

/* sv/sha1_message_digest.sv */
// ----------------------------------------------------------------------------
// sha1_message_digest: byte-serial SHA-1 digest engine
// Takes a message one byte per transaction, returns five 32-bit digest words.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------
//  item     | in        | item_valid / item_ready      | has_byte, data_byte,
//           |           |                              | last_byte
//  result   | out       | result_valid / result_ready  | digest_word,
//           |           |                              | word_index, last_word
//
//  Flow: byte transactions are taken while the sequencer is idle. Filling the
//  64th byte of a block starts a compression (80 rounds on the single round
//  unit, then the fold into the chaining words), and intake pauses until it
//  ends. A last transaction is followed by padding, one pad/length byte at a
//  time (up to 72 bytes), a step when the zero fill reaches the length field,
//  one or two compressions, and the readout of the five digest words.
//  Reset: chaining words take the initial values, length and fill clear.
//  Stalls: result_ready low holds the current word; the next transaction is
//  taken while the final digest word still waits in the output register.
//
// ----------------------------------------------------------------------------
module sha1_message_digest (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  sha1_pkg::item_t     item,
    output logic                result_valid,
    input  logic                result_ready,
    output sha1_pkg::result_t   result
);

    sha1_pkg::cmd_t    cmd;
    sha1_pkg::status_t sts;

    // sequencer: intake, padding, rounds, readout
    sha1_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .has_byte     (item.has_byte),
        .last_byte    (item.last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    // block register, round unit, chaining words, output register
    sha1_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (item.data_byte),
        .sts       (sts),
        .result    (result)
    );

    // the final-word flag matches the word index
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last_word == (result.word_index == sha1_pkg::WORD_LAST)))
        else $error("last_word does not match word_index");

    // word index never leaves 0..4
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.word_index <= sha1_pkg::WORD_LAST))
        else $error("word_index out of range");

    // ending a message always starts padding, so intake pauses
    a_last_pauses: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.last_byte) |=> !item_ready)
        else $error("intake did not pause after end of message");

    // a word delivered that is not the last is followed at once by the next
    a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !result.last_word) |=> result_valid)
        else $error("readout stopped before the final word");

endmodule
